// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker of the byte ring queue.
// Depends on nothing; every user must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising clock edge, skipped while reset is low.
`define BRQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define BRQ_ASSERT_NEVER(lbl, cond, msg) \
    `BRQ_ASSERT(lbl, !(cond), msg)

`endif

// ===== hdl/brq_pkg.sv =====
// Shared types and constants for the byte ring queue.
// No dependencies; used by the top level and the testbench.
package brq_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_mode;

    // Operation codes carried by the mode field
    localparam t_mode MODE_PUSH = 2'd0;
    localparam t_mode MODE_POP  = 2'd1;
    localparam t_mode MODE_CMP  = 2'd2;

    // Capacity register
    localparam int          CAP_W     = 9;
    localparam logic [8:0]  CAP_RESET = 9'd256;

    localparam t_byte BYTE_MASK = 8'hFF;

endpackage

// ===== hdl/brq_wrap_add.sv =====
// Shared ring address unit: (base + step) wrapped at the capacity in use.
// Both operands are below the capacity, so one compare and subtract wraps.
module brq_wrap_add #(
    parameter int DEPTH = 256,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic [PW-1:0] i_base,
    input  logic [PW-1:0] i_step,
    input  logic [CW-1:0] i_cap,
    output logic [PW-1:0] o_addr
);

    logic [PW:0] sum;
    logic [PW:0] cap_x;

    // Add, then fold back once past the capacity
    always_comb begin
        sum    = (PW+1)'(i_base) + (PW+1)'(i_step);
        cap_x  = (PW+1)'(i_cap);
        o_addr = (sum >= cap_x) ? PW'(sum - cap_x) : PW'(sum);
    end

endmodule

// ===== hdl/brq_ring.sv =====
// Byte ring storage: one write port, one read port with registered data.
// No dependencies.
module brq_ring #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    // Store a byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read a byte, data valid next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== hdl/byte_ring_queue_with_peek_compare.sv =====
// Top level of the byte ring queue: sequencer, pointers, result register.
// Uses brq_pkg, brq_wrap_add and brq_ring.
//
// Channel   Direction  Handshake                   Carries
// input     in         i_in_valid / o_in_stall     mode, byte, count, offset, flags
// output    out        o_out_valid / i_out_stall   byte, status, match, fill, last
// config    in         i_cfg_valid / o_cfg_ready   capacity (9 bits)
//
// One item at a time: the input stalls from acceptance until the item is finished and any result taken.
// Push: decided in S_DECIDE. Compare: S_DECIDE, then S_CMP when the offset is in range.
// Pop/peek of n bytes: S_DECIDE, then S_RD, S_RDW, S_POUT per byte through the single
// read port of the ring and the shared wrap adder; an output stall holds S_POUT.
// Reset is synchronous; the ring needs no clearing pass (unwritten entries are never read).
module byte_ring_queue_with_peek_compare #(
    parameter int DEPTH   = 256,
    parameter int MAX_RUN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_run_count,
    input  logic [7:0] i_head_offset,
    input  logic       i_first_of_run,
    input  logic       i_last_of_run,
    input  logic       i_consume,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_status,
    output logic       o_match,
    output logic [7:0] o_fill_level,
    output logic       o_last_result,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;
    localparam int FW = (PW > 8) ? PW : 8;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_RDW    = 3'd4;
    localparam logic [2:0] S_POUT   = 3'd5;
    localparam logic [2:0] S_HOLD   = 3'd6;

    // Clamp a written capacity to 2..DEPTH
    function automatic logic [CW-1:0] cap_clamp(input logic [brq_pkg::CAP_W-1:0] v);
        logic [CW-1:0] r;
        if (v < 9'd2) begin
            r = CW'(2);
        end else if (int'(v) > DEPTH) begin
            r = CW'(DEPTH);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    // control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cap, n_cap;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] r_fill, n_fill;
    logic          r_grp, n_grp;
    logic          r_msf, n_msf;
    logic [6:0]    r_idx, n_idx;
    logic          r_out_valid, n_out_valid;

    // latched item and result payload
    brq_pkg::t_mode r_mode;
    brq_pkg::t_byte r_byte;
    logic [6:0]     r_count;
    logic [7:0]     r_offs;
    logic           r_first, r_last, r_cons;
    brq_pkg::t_byte r_out_byte, n_out_byte;
    logic           r_status, n_status;
    logic           r_match, n_match;
    logic [7:0]     r_fill_lvl, n_fill_lvl;
    logic           r_last_res, n_last_res;
    logic           load_out;

    // datapath
    logic [PW-1:0]  au_base, au_step, au_addr;
    logic           mem_we, mem_re;
    brq_pkg::t_byte rd_data;
    logic [CW-1:0]  free_sp;
    logic [6:0]     run_len;
    logic [6:0]     need;
    logic           grp_eff, push_ok, msf_base, offs_in, hit;
    logic [PW-1:0]  pop_fill;
    logic [PW-1:0]  fill_sel;
    logic [FW-1:0]  fill_wide;
    logic           in_acc, cfg_acc, out_take;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_take = r_out_valid && !i_out_stall;

    // Hold off items while busy or while a capacity write is offered
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);

    // Item-level quantities
    always_comb begin
        free_sp  = r_cap - CW'(1) - CW'(r_fill);
        run_len  = (r_count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : r_count;
        need     = (r_count == 7'd0) ? 7'd1 : r_count;
        grp_eff  = r_first ? (XW'(need) <= XW'(free_sp)) : r_grp;
        push_ok  = grp_eff && (free_sp != '0);
        msf_base = r_first ? 1'b1 : r_msf;
        offs_in  = XW'(r_offs) < XW'(r_fill);
        hit      = (rd_data == (r_byte & brq_pkg::BYTE_MASK));
        pop_fill = r_cons ? (r_fill - PW'(run_len)) : r_fill;
    end

    // Select operands of the shared address unit
    always_comb begin
        au_base = r_head;
        au_step = '0;
        case (r_state)
            S_DECIDE: begin
                if (r_mode == brq_pkg::MODE_PUSH) begin
                    au_base = r_tail;
                    au_step = PW'(1);
                end else begin
                    au_step = PW'(r_offs);
                end
            end
            S_RD:    au_step = PW'(r_idx);
            S_POUT:  au_step = PW'(run_len);
            default: au_step = '0;
        endcase
    end

    brq_wrap_add #(.DEPTH(DEPTH)) u_wrap_add (
        .i_base (au_base),
        .i_step (au_step),
        .i_cap  (r_cap),
        .o_addr (au_addr)
    );

    assign mem_we = (r_state == S_DECIDE) && (r_mode == brq_pkg::MODE_PUSH) && push_ok;
    assign mem_re = ((r_state == S_DECIDE) && (r_mode == brq_pkg::MODE_CMP) && offs_in)
                 || (r_state == S_RD);

    brq_ring #(.DEPTH(DEPTH)) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_tail),
        .i_wr_data (r_byte),
        .i_rd_en   (mem_re),
        .i_rd_addr (au_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_grp       = r_grp;
        n_msf       = r_msf;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        load_out    = 1'b0;
        n_out_byte  = '0;
        n_status    = 1'b1;
        n_match     = 1'b0;
        n_last_res  = 1'b1;
        fill_sel    = r_fill;

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_cap  = cap_clamp(i_cfg_data);
                    n_head = '0;
                    n_tail = '0;
                    n_fill = '0;
                end else if (in_acc) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (r_mode)
                    brq_pkg::MODE_PUSH: begin
                        n_grp    = grp_eff;
                        load_out = 1'b1;
                        n_status = push_ok;
                        if (push_ok) begin
                            n_tail   = au_addr;
                            n_fill   = r_fill + PW'(1);
                            fill_sel = r_fill + PW'(1);
                        end
                        n_state = S_HOLD;
                    end
                    brq_pkg::MODE_POP: begin
                        if (run_len == 7'd0 || XW'(r_fill) < XW'(run_len)) begin
                            load_out = 1'b1;
                            n_status = (run_len == 7'd0);
                            n_state  = S_HOLD;
                        end else begin
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end
                    brq_pkg::MODE_CMP: begin
                        if (offs_in) begin
                            n_msf   = msf_base;
                            n_state = S_CMP;
                        end else if (r_last) begin
                            load_out = 1'b1;
                            n_match  = 1'b0;
                            n_msf    = 1'b1;
                            n_state  = S_HOLD;
                        end else begin
                            n_msf   = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CMP: begin
                if (r_last) begin
                    load_out = 1'b1;
                    n_match  = r_msf && hit;
                    n_msf    = 1'b1;
                    n_state  = S_HOLD;
                end else begin
                    n_msf   = r_msf && hit;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                load_out   = 1'b1;
                n_out_byte = rd_data;
                n_last_res = (r_idx == run_len - 7'd1);
                fill_sel   = pop_fill;
                n_state    = S_POUT;
            end
            S_POUT: begin
                if (out_take) begin
                    if (r_idx == run_len - 7'd1) begin
                        if (r_cons) begin
                            n_head = au_addr;
                            n_fill = pop_fill;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 7'd1;
                        n_state = S_RD;
                    end
                end
            end
            S_HOLD: begin
                if (out_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end
        fill_wide  = FW'(fill_sel);
        n_fill_lvl = fill_wide[7:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= cap_clamp(brq_pkg::CAP_RESET);
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_grp       <= 1'b0;
            r_msf       <= 1'b1;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_grp       <= n_grp;
            r_msf       <= n_msf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_byte  <= i_data_byte;
            r_count <= i_run_count;
            r_offs  <= i_head_offset;
            r_first <= i_first_of_run;
            r_last  <= i_last_of_run;
            r_cons  <= i_consume;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_byte <= n_out_byte;
            r_status   <= n_status;
            r_match    <= n_match;
            r_fill_lvl <= n_fill_lvl;
            r_last_res <= n_last_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_status      = r_status;
    assign o_match       = r_match;
    assign o_fill_level  = r_fill_lvl;
    assign o_last_result = r_last_res;

endmodule

// ===== hdl/brq_checker.sv =====
// Port-level checker for the byte ring queue, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module brq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_status,
    input logic       o_match,
    input logic       o_last_result,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready
);

    // A pending result stays until taken
    `BRQ_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped")

    // No new item while a result waits
    `BRQ_ASSERT(a_busy_out, o_out_valid |-> o_in_stall, "item accepted with result pending")

    // A refusal always carries the last-result flag of its item
    `BRQ_ASSERT(a_refuse_last, o_out_valid && !o_status |-> o_last_result, "refusal not last")

    // A match flag comes only on a final compare result
    `BRQ_ASSERT(a_match_form,
        o_out_valid && o_match |-> o_status && o_last_result && o_out_byte == 8'd0,
        "malformed match result")

    // A capacity write happens only when nothing is in flight
    `BRQ_ASSERT_NEVER(a_cfg_busy, i_cfg_valid && o_cfg_ready && o_out_valid,
        "capacity written with result pending")

endmodule

bind byte_ring_queue_with_peek_compare brq_checker u_brq_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_queue_with_peek_compare: a table of directed
// items, then random push groups, pops, peeks and compare runs over several capacities.
// Depends on brq_pkg and the block itself; every result is checked against a local predictor.
module tb_top;

    localparam int RING_DEPTH    = 256;
    localparam int RUN_MAX       = 64;
    localparam int SETTLE_CYCLES = 10;
    localparam int DIR_ROWS      = 25;
    localparam int SMALL_CAP_ROW = 19;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 38;
    localparam int MAX_REPORTS   = 10;

    // Mode value the block ignores
    localparam brq_pkg::t_mode MODE_NONE = 2'd3;

    typedef struct packed {
        brq_pkg::t_mode mode;
        brq_pkg::t_byte data;
        logic [6:0]     count;
        brq_pkg::t_byte offset;
        logic           first;
        logic           last;
        logic           consume;
    } t_ring_op;

    typedef struct packed {
        brq_pkg::t_byte value;
        logic           status;
        logic           match;
        brq_pkg::t_byte fill;
        logic           last;
    } t_ring_res;

    typedef struct packed {
        t_ring_op  op;
        logic      typed;
        t_ring_res want;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_mode;
    logic [7:0] i_data_byte;
    logic [6:0] i_run_count;
    logic [7:0] i_head_offset;
    logic       i_first_of_run;
    logic       i_last_of_run;
    logic       i_consume;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_status;
    logic       o_match;
    logic [7:0] o_fill_level;
    logic       o_last_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data;

    // Local copy of the queue state
    brq_pkg::t_byte ring_mem [RING_DEPTH];
    int unsigned    q_head = 0;
    int unsigned    q_tail = 0;
    bit             grp_ok = 1'b0;
    bit             run_match = 1'b1;
    logic [8:0]     cap_reg = brq_pkg::CAP_RESET;

    t_ring_res   awaited_results [$];
    t_dir_row    dir_rows [DIR_ROWS];
    logic [8:0]  cap_plan [NUM_PHASES] = '{9'd256, 9'd5, 9'd2, 9'd511, 9'd17, 9'd1,
                                          9'd64, 9'd3, 9'd256};

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cap_writes = 0;
    int unsigned err_count = 0;

    byte_ring_queue_with_peek_compare #(
        .DEPTH  (RING_DEPTH),
        .MAX_RUN(RUN_MAX)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_data_byte   (i_data_byte),
        .i_run_count   (i_run_count),
        .i_head_offset (i_head_offset),
        .i_first_of_run(i_first_of_run),
        .i_last_of_run (i_last_of_run),
        .i_consume     (i_consume),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_match       (o_match),
        .o_fill_level  (o_fill_level),
        .o_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #8_000_000;
        $display("Timeout with %0d results outstanding", awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // Ring size actually used, clamped to 2..depth
    function automatic int unsigned ring_size();
        if (cap_reg < 9'd2) return 2;
        if (cap_reg > 9'(RING_DEPTH)) return RING_DEPTH;
        return int'(cap_reg);
    endfunction

    function automatic int unsigned stored_bytes();
        int unsigned c;
        c = ring_size();
        return (q_tail + c - q_head) % c;
    endfunction

    function automatic void log_result(input brq_pkg::t_byte value, input bit status,
                                       input bit match, input bit last);
        t_ring_res res;
        res.value  = value;
        res.status = status;
        res.match  = match;
        res.fill   = brq_pkg::t_byte'(stored_bytes());
        res.last   = last;
        awaited_results.push_back(res);
    endfunction

    // Apply one accepted item to the local queue and queue up its results
    function automatic void predict_ring_op(input t_ring_op op);
        int unsigned    c;
        int unsigned    fill;
        int unsigned    room;
        int unsigned    n;
        int unsigned    need;
        int unsigned    k;
        bit             ok;
        bit             hit;
        brq_pkg::t_byte grab [RUN_MAX];
        c    = ring_size();
        fill = stored_bytes();
        room = c - 1 - fill;
        q_head = q_head % c;
        q_tail = q_tail % c;
        case (op.mode)
            brq_pkg::MODE_PUSH: begin
                // The first byte decides for the whole group
                if (op.first) begin
                    need = (op.count == 7'd0) ? 1 : int'(op.count);
                    grp_ok = (need <= room);
                end
                ok = grp_ok && (room >= 1);
                if (ok) begin
                    ring_mem[q_tail] = op.data;
                    q_tail = (q_tail + 1) % c;
                end
                log_result(8'h00, ok, 1'b0, 1'b1);
            end
            brq_pkg::MODE_POP: begin
                n = (int'(op.count) > RUN_MAX) ? RUN_MAX : int'(op.count);
                if (n == 0 || fill < n) begin
                    log_result(8'h00, n == 0, 1'b0, 1'b1);
                end else begin
                    for (k = 0; k < n; k++) grab[k] = ring_mem[(q_head + k) % c];
                    if (op.consume) q_head = (q_head + n) % c;
                    for (k = 0; k < n; k++) log_result(grab[k], 1'b1, 1'b0, k + 1 == n);
                end
            end
            brq_pkg::MODE_CMP: begin
                if (op.first) run_match = 1'b1;
                hit = (op.offset < fill) && (ring_mem[(q_head + op.offset) % c] == op.data);
                run_match = run_match && hit;
                if (op.last) begin
                    log_result(8'h00, 1'b1, run_match, 1'b1);
                    run_match = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_ring_op random_op();
        t_ring_op op;
        op.mode    = brq_pkg::t_mode'($urandom_range(2));
        op.data    = brq_pkg::t_byte'($urandom);
        op.count   = 7'($urandom);
        op.offset  = brq_pkg::t_byte'($urandom);
        op.first   = 1'($urandom);
        op.last    = 1'($urandom);
        op.consume = 1'($urandom);
        return op;
    endfunction

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Present one item, hold it until accepted, then predict
    task automatic send_item(input t_ring_op op);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= op.mode;
        i_data_byte    <= op.data;
        i_run_count    <= op.count;
        i_head_offset  <= op.offset;
        i_first_of_run <= op.first;
        i_last_of_run  <= op.last;
        i_consume      <= op.consume;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_ring_op(op);
        if (op.mode != MODE_NONE) items_sent++;
    endtask

    // Drain, let the block settle, then write the capacity register
    task automatic set_capacity(input logic [8:0] cap);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_data  <= cap;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_reg = cap;
        q_head  = 0;
        q_tail  = 0;
        cap_writes++;
    endtask

    // Compare run over consecutive head offsets, mostly with the stored bytes
    task automatic compare_run(input int unsigned base, input int unsigned len,
                               input int unsigned hit_pct);
        t_ring_op    op;
        int unsigned k;
        int unsigned off;
        for (k = 0; k < len; k++) begin
            op = random_op();
            op.mode = brq_pkg::MODE_CMP;
            off = base + k;
            if ($urandom_range(9) == 0) off = $urandom_range(255);
            op.offset = brq_pkg::t_byte'(off);
            op.first  = (k == 0);
            op.last   = (k == len - 1);
            if (off < stored_bytes() && $urandom_range(99) < hit_pct)
                op.data = ring_mem[(q_head + off) % ring_size()];
            send_item(op);
        end
    endtask

    // Random receiver stall, quiet during reset
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_ring_res got;
        t_ring_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_out_byte, o_status, o_match, o_fill_level, o_last_result};
            results_seen++;
            if (awaited_results.size() == 0) begin
                flag_error($sformatf({"%0t: unexpected result byte %02h st %0d m %0d ",
                    "fill %0d last %0d"},
                    $time, got.value, got.status, got.match, got.fill, got.last));
            end else begin
                want = awaited_results.pop_front();
                if (got !== want)
                    flag_error($sformatf({"%0t: mismatch, expected byte %02h st %0d m %0d ",
                        "fill %0d last %0d, got byte %02h st %0d m %0d fill %0d last %0d"},
                        $time, want.value, want.status, want.match, want.fill, want.last,
                        got.value, got.status, got.match, got.fill, got.last));
            end
        end
    end

    initial begin : main_seq
        t_ring_op    op;
        int unsigned r;
        int unsigned ph;
        int unsigned goal;
        int unsigned pick;
        int unsigned fill;
        int unsigned room;
        int unsigned len;
        int unsigned k;
        int unsigned decl;

        // Drive every input to a known value and hold reset
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_mode         <= brq_pkg::MODE_PUSH;
        i_data_byte    <= 8'h00;
        i_run_count    <= 7'd0;
        i_head_offset  <= 8'h00;
        i_first_of_run <= 1'b0;
        i_last_of_run  <= 1'b0;
        i_consume      <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= brq_pkg::CAP_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: op fields, typed flag, typed result (byte st match fill last)
        dir_rows = '{
            // empty queue: pop too short, pop of zero, compare out of range
            '{'{brq_pkg::MODE_POP, 8'h00, 7'd1, 8'h00, 1'b0, 1'b0, 1'b1},
              1'b1, '{8'h00, 1'b0, 1'b0, 8'd0, 1'b1}},
            '{'{brq_pkg::MODE_POP, 8'h00, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd0, 1'b1}},
            '{'{brq_pkg::MODE_CMP, 8'h00, 7'd1, 8'h00, 1'b1, 1'b1, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd0, 1'b1}},
            // group of three plus one extra byte
            '{'{brq_pkg::MODE_PUSH, 8'h00, 7'd3, 8'hFF, 1'b1, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd1, 1'b1}},
            '{'{brq_pkg::MODE_PUSH, 8'hFF, 7'd0, 8'h00, 1'b0, 1'b0, 1'b1},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd2, 1'b1}},
            '{'{brq_pkg::MODE_PUSH, 8'hA5, 7'h7F, 8'h00, 1'b0, 1'b1, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd3, 1'b1}},
            '{'{brq_pkg::MODE_PUSH, 8'h5A, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd4, 1'b1}},
            // peek two
            '{'{brq_pkg::MODE_POP, 8'h00, 7'd2, 8'h00, 1'b0, 1'b0, 1'b0},
              1'b0, '0},
            // matching compare run over three bytes
            '{'{brq_pkg::MODE_CMP, 8'h00, 7'd1, 8'h00, 1'b1, 1'b0, 1'b0},
              1'b0, '0},
            '{'{brq_pkg::MODE_CMP, 8'hFF, 7'd1, 8'h01, 1'b0, 1'b0, 1'b0},
              1'b0, '0},
            '{'{brq_pkg::MODE_CMP, 8'h5A, 7'd1, 8'h03, 1'b0, 1'b1, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b1, 8'd4, 1'b1}},
            // offset beyond fill level
            '{'{brq_pkg::MODE_CMP, 8'h00, 7'd1, 8'hFF, 1'b1, 1'b1, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd4, 1'b1}},
            // run that fails on its second byte
            '{'{brq_pkg::MODE_CMP, 8'h00, 7'd0, 8'h00, 1'b1, 1'b0, 1'b1},
              1'b0, '0},
            '{'{brq_pkg::MODE_CMP, 8'h00, 7'd0, 8'h02, 1'b0, 1'b1, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd4, 1'b1}},
            // unused mode
            '{'{MODE_NONE, 8'hFF, 7'h7F, 8'hFF, 1'b1, 1'b1, 1'b1},
              1'b0, '0},
            // pop count above the run limit, then pop all four
            '{'{brq_pkg::MODE_POP, 8'h00, 7'h7F, 8'h00, 1'b0, 1'b0, 1'b1},
              1'b1, '{8'h00, 1'b0, 1'b0, 8'd4, 1'b1}},
            '{'{brq_pkg::MODE_POP, 8'h00, 7'd4, 8'h00, 1'b0, 1'b0, 1'b1},
              1'b0, '0},
            // group count zero, then the largest group count
            '{'{brq_pkg::MODE_PUSH, 8'h80, 7'd0, 8'h00, 1'b1, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd1, 1'b1}},
            '{'{brq_pkg::MODE_PUSH, 8'h7F, 7'h7F, 8'h00, 1'b1, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd2, 1'b1}},
            // capacity 0 acts as 2: group too large, orphan byte, full queue
            '{'{brq_pkg::MODE_PUSH, 8'h11, 7'd2, 8'h00, 1'b1, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b0, 1'b0, 8'd0, 1'b1}},
            '{'{brq_pkg::MODE_PUSH, 8'h22, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b0, 1'b0, 8'd0, 1'b1}},
            '{'{brq_pkg::MODE_PUSH, 8'h33, 7'd1, 8'h00, 1'b1, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b1, 1'b0, 8'd1, 1'b1}},
            '{'{brq_pkg::MODE_PUSH, 8'h44, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0},
              1'b1, '{8'h00, 1'b0, 1'b0, 8'd1, 1'b1}},
            '{'{brq_pkg::MODE_POP, 8'h00, 7'd1, 8'h00, 1'b0, 1'b0, 1'b1},
              1'b1, '{8'h33, 1'b1, 1'b0, 8'd0, 1'b1}},
            // wrap the tail around the two-entry ring
            '{'{brq_pkg::MODE_PUSH, 8'h55, 7'd1, 8'h00, 1'b1, 1'b0, 1'b0},
              1'b0, '0}
        };

        set_capacity(brq_pkg::CAP_RESET);
        for (r = 0; r < DIR_ROWS; r++) begin
            if (r == SMALL_CAP_ROW) set_capacity(9'd0);
            send_item(dir_rows[r].op);
            // Swap in the hand-written result where the row has one
            if (dir_rows[r].typed) begin
                void'(awaited_results.pop_back());
                awaited_results.push_back(dir_rows[r].want);
            end
        end

        // Random phases, one capacity each
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_capacity(cap_plan[ph]);
            if (ph < 3) begin
                tx_idle_pct = 29;
                rx_idle_pct = 80;
            end else if (ph < 6) begin
                tx_idle_pct = 80;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                fill = stored_bytes();
                pick = $urandom_range(99);
                if (pick < 40) begin
                    // push group, sized to fit most of the time
                    room = ring_size() - 1 - fill;
                    if ($urandom_range(3) == 0 || room == 0)
                        len = $urandom_range(12, 1);
                    else
                        len = $urandom_range((room > 10) ? 10 : room, 1);
                    decl = len;
                    if ($urandom_range(7) == 0) decl = $urandom_range(127);
                    for (k = 0; k < len; k++) begin
                        op = random_op();
                        op.mode  = brq_pkg::MODE_PUSH;
                        op.first = (k == 0);
                        if (k == 0) op.count = 7'(decl);
                        send_item(op);
                    end
                end else if (pick < 62) begin
                    // pop or peek: short, everything, or any count
                    op = random_op();
                    op.mode = brq_pkg::MODE_POP;
                    k = $urandom_range(9);
                    if (k == 1)
                        op.count = 7'((fill > RUN_MAX) ? RUN_MAX : fill);
                    else if (k > 1 && fill != 0)
                        op.count = 7'($urandom_range((fill > 8) ? 8 : fill, 1));
                    send_item(op);
                end else if (pick < 77) begin
                    compare_run((fill == 0) ? 0 : $urandom_range(fill - 1),
                                $urandom_range(4, 1), 85);
                end else if (pick < 85) begin
                    // frame check: head bytes, then tail bytes
                    len = (fill == 0) ? 1 : ((fill < 3) ? fill : 3);
                    compare_run(0, len, 100);
                    compare_run((fill >= len) ? fill - len : 0, len, 100);
                end else begin
                    // noise: any mode, any flags
                    op = random_op();
                    op.mode = brq_pkg::t_mode'($urandom_range(3));
                    send_item(op);
                end
            end
        end

        // Drain and let the block go quiet
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results over %0d capacity writes.",
                 items_sent, results_seen, cap_writes);
        $display("Mismatches and unexpected results: %0d", err_count);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/brq_pkg.sv
hdl/brq_wrap_add.sv
hdl/brq_ring.sv
hdl/byte_ring_queue_with_peek_compare.sv
hdl/brq_checker.sv
tb/tb_top.sv
